>>> rtl/core/sso_pkg.sv
`timescale 1ns / 1ps
package sso_pkg;

	localparam logic [3:0] NONE_PRED = 4'd15;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_string;
		logic       end_of_set;
	} sso_in_t;

	typedef struct packed {
		logic [3:0] string_index;
		logic [4:0] skip_chars;
		logic [7:0] super_length;
		logic       overflow;
		logic       last;
	} sso_res_t;

endpackage

>>> rtl/core/sso_ram.sv
`timescale 1ns / 1ps
module sso_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/shortest_superstring_order.sv
`timescale 1ns / 1ps
// Characters load one per cycle while busy is low. An item with end_of_set
// closes the set and raises busy for the whole solve: the pairwise overlaps,
// then the subset pass (one read of the best-overlap memory per cycle), then
// the trace-back and the results. Results appear on result with strobe high
// for one cycle each and must be taken then; the receiver cannot stall them.
module shortest_superstring_order #(
	parameter int MAX_STRINGS = 12,
	parameter int MAX_LEN     = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sso_pkg::sso_in_t item,
	output logic             busy,
	output logic             strobe,
	output sso_pkg::sso_res_t result
);
	import sso_pkg::*;

	localparam int SW = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
	localparam int CW = $clog2(MAX_STRINGS + 1);
	localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int BW = $clog2(MAX_STRINGS * MAX_LEN + 1);
	localparam int MW = MAX_STRINGS;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_OV_LA  = 4'd1;
	localparam logic [3:0] S_OV_LB  = 4'd2;
	localparam logic [3:0] S_OV_RD  = 4'd3;
	localparam logic [3:0] S_OV_CMP = 4'd4;
	localparam logic [3:0] S_OV_WR  = 4'd5;
	localparam logic [3:0] S_DP_SEL = 4'd6;
	localparam logic [3:0] S_DP_RUN = 4'd7;
	localparam logic [3:0] S_DP_DRN = 4'd8;
	localparam logic [3:0] S_FIN    = 4'd9;
	localparam logic [3:0] S_FDRN   = 4'd10;
	localparam logic [3:0] S_TB_RD  = 4'd11;
	localparam logic [3:0] S_TB_GET = 4'd12;
	localparam logic [3:0] S_OUT_RD = 4'd13;
	localparam logic [3:0] S_EMIT   = 4'd14;

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q, n_q;
	logic [LW-1:0] pos_q;
	logic          ovf_flag_q, ovf_q;
	logic [BW-1:0] total_q;
	logic [MW-1:0] full_q, nm_q, bm_q;
	logic [LW-1:0] len_q [MAX_STRINGS];
	logic [SW-1:0] order_q [MAX_STRINGS];

	logic [SW-1:0] a_q, b_q, j_q, i_q, i_s1, cur_q, prev_q, out_q, idx_q;
	logic [LW-1:0] la_q, k_q, t_q, ovv_q;
	logic [BW-1:0] acc_q, fmax_q;
	logic [3:0]    pid_q;
	logic [SW-1:0] end_q;
	logic          v_s1;
	logic [7:0]    slen_q;

	logic          accept, has_room, pos_room, closes;
	logic [LW-1:0] pos_new;
	logic [CW-1:0] cnt_new;

	logic [7:0]         cha_rd, chb_rd;
	logic [LW-1:0]      ov_rd;
	logic [BW-1:0]      best_rd;
	logic [3:0]         pred_rd;
	logic [SW+PW-1:0]   ch_wa, ch_ra, ch_rb;
	logic [2*SW-1:0]    ov_wa, ov_ra;
	logic [MW+SW-1:0]   dp_wa, dp_ra;
	logic               ov_we, dp_we;
	logic [BW-1:0]      dp_wbest;
	logic [3:0]         dp_wpred;

	logic [MW-1:0] m_c;
	logic [LW-1:0] len_rd, lb_min;
	logic          j_last, i_last, b_last, a_last, out_last, nm_full;
	logic [BW-1:0] cand, acc_n, fmax_n;
	logic [3:0]    pid_n;
	logic [SW-1:0] end_n;
	logic          upd, fupd;
	logic [LW-1:0] a_off;

	assign has_room = cnt_q != CW'(MAX_STRINGS);
	assign pos_room = pos_q != LW'(MAX_LEN);
	assign accept   = start && (state_q == S_IDLE);
	assign closes   = item.end_of_string || item.end_of_set;
	assign pos_new  = (has_room && pos_room) ? pos_q + LW'(1) : pos_q;
	assign cnt_new  = (closes && has_room) ? cnt_q + CW'(1) : cnt_q;

	assign m_c      = nm_q & ~(MW'(1) << j_q);
	assign len_rd   = len_q[(state_q == S_OV_LA) ? a_q : b_q];
	assign lb_min   = (la_q < len_rd) ? la_q : len_rd;
	assign j_last   = CW'(j_q) + CW'(1) == n_q;
	assign i_last   = CW'(i_q) + CW'(1) == n_q;
	assign b_last   = CW'(b_q) + CW'(1) == n_q;
	assign a_last   = CW'(a_q) + CW'(1) == n_q;
	assign out_last = CW'(out_q) + CW'(1) == n_q;
	assign nm_full  = nm_q == full_q;

	assign cand   = best_rd + BW'(ov_rd);
	assign upd    = v_s1 && (cand >= acc_q);
	assign acc_n  = upd ? cand : acc_q;
	assign pid_n  = upd ? 4'(i_s1) : pid_q;
	assign fupd   = v_s1 && ((i_s1 == '0) || (best_rd > fmax_q));
	assign fmax_n = fupd ? best_rd : fmax_q;
	assign end_n  = fupd ? i_s1 : end_q;

	assign a_off = la_q - k_q + t_q;
	assign ch_wa = {cnt_q[SW-1:0], pos_q[PW-1:0]};
	assign ch_ra = {a_q, a_off[PW-1:0]};
	assign ch_rb = {b_q, t_q[PW-1:0]};
	assign ov_we = state_q == S_OV_WR;
	assign ov_wa = {a_q, b_q};
	assign ov_ra = (state_q == S_DP_RUN) ? {i_q, j_q} : {prev_q, order_q[out_q]};
	assign dp_wa = {nm_q, j_q};
	assign dp_we = (state_q == S_DP_DRN) || ((state_q == S_DP_SEL) && nm_q[j_q] && (m_c == '0));
	assign dp_wbest = (state_q == S_DP_DRN) ? acc_n : '0;
	assign dp_wpred = (state_q == S_DP_DRN) ? pid_n : NONE_PRED;

	always_comb begin
		unique case (state_q)
			S_DP_RUN: dp_ra = {m_c, i_q};
			S_FIN:    dp_ra = {full_q, i_q};
			default:  dp_ra = {bm_q, cur_q};
		endcase
	end

	sso_ram #(.WIDTH(8), .DEPTH(2 ** (SW + PW))) u_cha (
		.clk(clk), .we(accept && has_room && pos_room), .waddr(ch_wa), .wdata(item.ch),
		.raddr(ch_ra), .rdata(cha_rd));
	sso_ram #(.WIDTH(8), .DEPTH(2 ** (SW + PW))) u_chb (
		.clk(clk), .we(accept && has_room && pos_room), .waddr(ch_wa), .wdata(item.ch),
		.raddr(ch_rb), .rdata(chb_rd));
	sso_ram #(.WIDTH(LW), .DEPTH(2 ** (2 * SW))) u_ov (
		.clk(clk), .we(ov_we), .waddr(ov_wa), .wdata(ovv_q),
		.raddr(ov_ra), .rdata(ov_rd));
	sso_ram #(.WIDTH(BW), .DEPTH(2 ** (MW + SW))) u_best (
		.clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wbest),
		.raddr(dp_ra), .rdata(best_rd));
	sso_ram #(.WIDTH(4), .DEPTH(2 ** (MW + SW))) u_pred (
		.clk(clk), .we(dp_we), .waddr(dp_wa), .wdata(dp_wpred),
		.raddr(dp_ra), .rdata(pred_rd));

	always_ff @(posedge clk) begin
		if (accept && closes && has_room) begin
			len_q[cnt_q[SW-1:0]] <= pos_new;
		end
		if (state_q == S_FDRN) begin
			order_q[SW'(n_q - CW'(1))] <= end_n;
		end
		if (state_q == S_TB_GET) begin
			order_q[idx_q - SW'(1)] <= pred_rd[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			pos_q      <= '0;
			ovf_flag_q <= 1'b0;
			total_q    <= '0;
			v_s1       <= 1'b0;
		end else begin
			v_s1 <= ((state_q == S_DP_RUN) && m_c[i_q]) || (state_q == S_FIN);
			i_s1 <= i_q;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q      <= closes ? '0 : pos_new;
						cnt_q      <= cnt_new;
						ovf_flag_q <= ovf_flag_q || !(has_room && pos_room);
						if (closes && has_room) begin
							total_q <= total_q + BW'(pos_new);
						end
						if (item.end_of_set) begin
							cnt_q      <= '0;
							pos_q      <= '0;
							ovf_flag_q <= 1'b0;
							ovf_q      <= ovf_flag_q || !(has_room && pos_room);
							n_q        <= cnt_new;
							for (int x = 0; x < MW; x++) begin
								full_q[x] <= CW'(x) < cnt_new;
							end
							a_q     <= '0;
							b_q     <= '0;
							state_q <= S_OV_LA;
						end
					end
				end
				S_OV_LA: begin
					la_q    <= len_rd;
					state_q <= S_OV_LB;
				end
				S_OV_LB: begin
					k_q <= lb_min;
					t_q <= '0;
					if (a_q == b_q || lb_min == '0) begin
						ovv_q   <= '0;
						state_q <= S_OV_WR;
					end else begin
						state_q <= S_OV_RD;
					end
				end
				S_OV_RD: state_q <= S_OV_CMP;
				S_OV_CMP: begin
					if (cha_rd == chb_rd) begin
						if (t_q + LW'(1) == k_q) begin
							ovv_q   <= k_q;
							state_q <= S_OV_WR;
						end else begin
							t_q     <= t_q + LW'(1);
							state_q <= S_OV_RD;
						end
					end else if (k_q == LW'(1)) begin
						ovv_q   <= '0;
						state_q <= S_OV_WR;
					end else begin
						k_q     <= k_q - LW'(1);
						t_q     <= '0;
						state_q <= S_OV_RD;
					end
				end
				S_OV_WR: begin
					if (b_last) begin
						b_q <= '0;
						if (a_last) begin
							nm_q    <= MW'(1);
							j_q     <= '0;
							state_q <= S_DP_SEL;
						end else begin
							a_q     <= a_q + SW'(1);
							state_q <= S_OV_LA;
						end
					end else begin
						b_q     <= b_q + SW'(1);
						state_q <= S_OV_LB;
					end
				end
				S_DP_SEL, S_DP_DRN: begin
					if (state_q == S_DP_SEL && nm_q[j_q] && m_c != '0) begin
						i_q     <= '0;
						acc_q   <= '0;
						pid_q   <= NONE_PRED;
						state_q <= S_DP_RUN;
					end else if (j_last) begin
						j_q <= '0;
						if (nm_full) begin
							i_q     <= '0;
							fmax_q  <= '0;
							end_q   <= '0;
							state_q <= S_FIN;
						end else begin
							nm_q    <= nm_q + MW'(1);
							state_q <= S_DP_SEL;
						end
					end else begin
						j_q     <= j_q + SW'(1);
						state_q <= S_DP_SEL;
					end
				end
				S_DP_RUN: begin
					acc_q <= acc_n;
					pid_q <= pid_n;
					if (i_last) begin
						state_q <= S_DP_DRN;
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				S_FIN: begin
					fmax_q <= fmax_n;
					end_q  <= end_n;
					if (i_last) begin
						state_q <= S_FDRN;
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				S_FDRN: begin
					slen_q <= 8'(total_q - fmax_n);
					cur_q  <= end_n;
					bm_q   <= full_q;
					idx_q  <= SW'(n_q - CW'(1));
					out_q  <= '0;
					state_q <= (n_q == CW'(1)) ? S_OUT_RD : S_TB_RD;
				end
				S_TB_RD: state_q <= S_TB_GET;
				S_TB_GET: begin
					bm_q  <= bm_q & ~(MW'(1) << cur_q);
					cur_q <= pred_rd[SW-1:0];
					idx_q <= idx_q - SW'(1);
					state_q <= (idx_q == SW'(1)) ? S_OUT_RD : S_TB_RD;
				end
				S_OUT_RD: state_q <= S_EMIT;
				S_EMIT: begin
					prev_q <= order_q[out_q];
					if (out_last) begin
						total_q <= '0;
						state_q <= S_IDLE;
					end else begin
						out_q   <= out_q + SW'(1);
						state_q <= S_OUT_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign strobe = state_q == S_EMIT;

	always_comb begin
		result.string_index = 4'(order_q[out_q]);
		result.skip_chars   = (out_q == '0) ? 5'd0 : 5'(ov_rd);
		result.super_length = slen_q;
		result.overflow     = ovf_q;
		result.last         = out_last;
	end
endmodule

>>> rtl/core/sso_checker.sv
`timescale 1ns / 1ps
module sso_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input sso_pkg::sso_in_t  item,
	input logic              busy,
	input logic              strobe,
	input sso_pkg::sso_res_t result
);
	import sso_pkg::*;

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result transfer outside solve");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && item.end_of_set)) else $error("busy without set close");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !busy) else $error("busy after last result");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("back-to-back result transfers");
endmodule

bind shortest_superstring_order sso_checker u_sso_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .item(item),
	.busy(busy), .strobe(strobe), .result(result));

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import sso_pkg::*;

	localparam int NSTR = 12;
	localparam int NLEN = 20;
	localparam int WDOG_LIMIT = 3000000;

	typedef struct {
		int         len;
		logic [7:0] base;
		logic [7:0] step;
		bit         eos;
		bit         eset;
		bit         typed;
		sso_res_t   res;
	} str_row_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	sso_in_t  item;
	logic     busy;
	logic     strobe;
	sso_res_t result;

	sso_res_t expected_order[$];
	str_row_t str_table[$];
	int       fails;
	int       sent;
	int       idle_pct;
	int       quiet_cycles;

	// predictor state
	logic [7:0] chars[NSTR][NLEN];
	int         slen[NSTR];
	int         scount;
	int         spos;
	bit         dropped;
	int         ovl[NSTR][NSTR];
	int         best[1 << NSTR][NSTR];
	int         pred[1 << NSTR][NSTR];

	shortest_superstring_order i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int suffix_prefix(int a, int b);
		int k;
		bit same;
		for (k = (slen[a] < slen[b]) ? slen[a] : slen[b]; k > 0; k--) begin
			same = 1'b1;
			for (int c = 0; c < k; c++)
				if (chars[a][slen[a] - k + c] != chars[b][c]) same = 1'b0;
			if (same) return k;
		end
		return 0;
	endfunction

	// computes the superstring ordering of the stored set, queues its results
	function automatic void order_set(ref sso_res_t res_q[$]);
		int n;
		int full;
		int total;
		int fin;
		int cur;
		int idx;
		int bm;
		int p;
		int cand;
		int src;
		int order[NSTR];
		sso_res_t r;
		n = scount;
		full = (1 << n) - 1;
		total = 0;
		fin = 0;
		for (int i = 0; i < n; i++) begin
			total += slen[i];
			for (int j = 0; j < n; j++) ovl[i][j] = (i == j) ? 0 : suffix_prefix(i, j);
		end
		for (int m = 0; m <= full; m++)
			for (int i = 0; i < NSTR; i++) begin
				best[m][i] = 0;
				pred[m][i] = NONE_PRED;
			end
		for (int m = 1; m < full; m++)
			for (int i = 0; i < n; i++) begin
				if (!m[i]) continue;
				for (int j = 0; j < n; j++) begin
					if (m[j]) continue;
					cand = best[m][i] + ovl[i][j];
					if (cand >= best[m | (1 << j)][j]) begin
						best[m | (1 << j)][j] = cand;
						pred[m | (1 << j)][j] = i;
					end
				end
			end
		for (int i = 1; i < n; i++)
			if (best[full][i] > best[full][fin]) fin = i;
		idx = n - 1;
		order[idx] = fin;
		cur = fin;
		bm = full;
		while (idx > 0) begin
			p = pred[bm][cur];
			if (p >= n) break;
			bm &= ~(1 << cur);
			cur = p;
			idx--;
			order[idx] = p;
		end
		for (int i = 0; i < n; i++) begin
			src = (i < idx) ? order[idx] : order[i];
			r.string_index = src[3:0];
			r.skip_chars   = (i == 0) ? 5'd0 : 5'(ovl[order[i - 1]][src]);
			r.super_length = 8'(total - best[full][fin]);
			r.overflow     = dropped;
			r.last         = (i == n - 1);
			res_q = {res_q, r};
		end
	endfunction

	function automatic void load_char(sso_in_t x, ref sso_res_t res_q[$]);
		if (scount < NSTR) begin
			if (spos < NLEN) begin
				chars[scount][spos] = x.ch;
				spos++;
			end else begin
				dropped = 1'b1;
			end
		end else begin
			dropped = 1'b1;
		end
		if (x.end_of_string || x.end_of_set) begin
			if (scount < NSTR) begin
				slen[scount] = spos;
				scount++;
			end
			spos = 0;
		end
		if (x.end_of_set) begin
			if (scount > 0) order_set(res_q);
			scount = 0;
			spos = 0;
			dropped = 1'b0;
		end
	endfunction

	task automatic send_char(sso_in_t x, bit typed, sso_res_t typed_res);
		int gap;
		sso_res_t got[$];
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= x;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		load_char(x, got);
		if (typed && got.size() > 0) expected_order = {expected_order, typed_res};
		else foreach (got[k]) expected_order = {expected_order, got[k]};
		sent++;
		if (sent == 45) idle_pct = 66;
		if (sent == 90) idle_pct = 0;
	endtask

	task automatic send_row(str_row_t row);
		sso_in_t x;
		for (int k = 0; k < row.len; k++) begin
			x.ch = row.base + 8'(k) * row.step;
			x.end_of_string = (k == row.len - 1) && row.eos;
			x.end_of_set = (k == row.len - 1) && row.eset;
			send_char(x, row.typed, row.res);
		end
	endtask

	task automatic item_rand(bit fin, bit eos, bit eset);
		sso_in_t x;
		x.ch = 8'($urandom);
		x.end_of_string = fin && eos;
		x.end_of_set = fin && eset;
		send_char(x, 0, '0);
	endtask

	function automatic void add_row(int len, logic [7:0] base, logic [7:0] step, bit eos,
			bit eset, bit typed, sso_res_t res);
		str_row_t row;
		row.len = len;
		row.base = base;
		row.step = step;
		row.eos = eos;
		row.eset = eset;
		row.typed = typed;
		row.res = res;
		str_table = {str_table, row};
	endfunction

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (expected_order.size() == 0) begin
				$display("%0t: unexpected transfer %p", $realtime, result);
				fails++;
			end else begin
				if (result.string_index !== expected_order[0].string_index
						|| result.skip_chars !== expected_order[0].skip_chars
						|| result.super_length !== expected_order[0].super_length
						|| result.overflow !== expected_order[0].overflow
						|| result.last !== expected_order[0].last) begin
					$display("%0t: expected %p actual %p", $realtime, expected_order[0], result);
					fails++;
				end
				void'(expected_order.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		sso_res_t none;
		str_row_t row;
		int n;
		bit long_str;
		none = '0;
		fails = 0;
		sent = 0;
		idle_pct = 38;
		quiet_cycles = 0;
		scount = 0;
		spos = 0;
		dropped = 1'b0;
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_row(1, 8'h00, 8'h00, 1, 1, 1, '{4'd0, 5'd0, 8'd1, 1'b0, 1'b1});
		// set mark closes an open string
		add_row(1, 8'hFF, 8'h00, 0, 1, 1, '{4'd0, 5'd0, 8'd1, 1'b0, 1'b1});
		// over-long string is cut
		add_row(21, 8'h41, 8'h01, 1, 1, 1, '{4'd0, 5'd0, 8'd20, 1'b1, 1'b1});
		add_row(3, 8'h41, 8'h01, 1, 0, 0, none);
		add_row(3, 8'h42, 8'h01, 1, 0, 0, none);
		add_row(3, 8'h43, 8'h01, 1, 1, 0, none);
		// equal strings: ties everywhere
		add_row(2, 8'h41, 8'h00, 1, 0, 0, none);
		add_row(2, 8'h41, 8'h00, 1, 0, 0, none);
		add_row(2, 8'h41, 8'h00, 1, 1, 0, none);
		// one string too many
		for (int k = 0; k < NSTR; k++) add_row(1, 8'(8'h30 + k), 8'h00, 1, 0, 0, none);
		add_row(1, 8'h80, 8'h00, 1, 1, 0, none);
		foreach (str_table[k]) send_row(str_table[k]);

		while (sent < 110) begin
			n = ($urandom_range(7) == 0) ? 6 : $urandom_range(1, 5);
			for (int s = 0; s < n; s++) begin
				long_str = ($urandom_range(11) == 0);
				row.len = long_str ? $urandom_range(21, 24) : $urandom_range(1, 5);
				row.eos = (s < n - 1) || ($urandom_range(3) != 0);
				row.eset = (s == n - 1);
				row.typed = 0;
				row.res = none;
				if ($urandom_range(9) == 0) begin
					for (int k = 0; k < row.len; k++) begin
						item_rand(k == row.len - 1, row.eos, row.eset);
					end
				end else begin
					row.base = 8'h41 + 8'($urandom_range(1));
					row.step = 8'($urandom_range(1));
					send_row(row);
				end
			end
		end
		start <= 1'b0;
		wait (expected_order.size() == 0);
		repeat (100) @(posedge clk);
		if (fails == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
